### rtl/roilmgv_pkg.sv
// ----------------------------------------------------------------------------
// roilmgv_pkg
// Shared widths, constants and types for the region-of-interest luma mean and
// green variance statistics block.
// ----------------------------------------------------------------------------
package roilmgv_pkg;

    // Frame geometry
    localparam int MAX_DIM   = 2048;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int COL_W     = $clog2(MAX_DIM);
    localparam int ROW_W     = $clog2(MAX_DIM + 1);
    localparam int REG_S_W   = CFG_W + 2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(320);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(240);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_REGION_LEFT   = 3'd2,
        CFG_REGION_TOP    = 3'd3,
        CFG_REGION_WIDTH  = 3'd4,
        CFG_REGION_HEIGHT = 3'd5
    } t_cfg_idx;

    // Pixel format
    localparam int PIX_W   = 16;
    localparam int RED_W   = 5;
    localparam int GREEN_W = 6;
    localparam int BLUE_W  = 5;

    // Luma = (r*8*299 + g*4*587 + b*8*114) / 1000, division by reciprocal
    localparam int LUMA_R_WT   = 8 * 299;
    localparam int LUMA_G_WT   = 4 * 587;
    localparam int LUMA_B_WT   = 8 * 114;
    localparam int LUMA_DIV    = 1000;
    localparam int LUMA_SHIFT  = 28;
    localparam int LUMA_RECIP  = ((1 << LUMA_SHIFT) + LUMA_DIV - 1) / LUMA_DIV;
    localparam int WSUM_W      = 18;
    localparam int RECIP_W     = 19;
    localparam int LUMA_PROD_W = WSUM_W + RECIP_W;
    localparam int LUMA_W      = 8;
    localparam int GSQR_W      = 2 * GREEN_W;

    // Frame accumulators
    localparam int CNT_W  = 23;
    localparam int LSUM_W = 30;
    localparam int GSUM_W = 28;
    localparam int GSQ_W  = 34;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [LSUM_W-1:0] luma_sum;
        logic [GSUM_W-1:0] green_sum;
        logic [GSQ_W-1:0]  green_sq_sum;
    } t_frame_stats;

    // Frame queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Result formats
    localparam int FRAC_BITS = 8;
    localparam int MEAN_W    = 16;
    localparam int VAR_W     = 18;

    // Partial-product multiplier and products
    localparam int MUL_A_W = GSUM_W;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NG_W    = CNT_W + GSQ_W;
    localparam int GG_W    = 2 * GSUM_W;
    localparam int NN_W    = 46;
    localparam int DEV_W   = 54;

    // Long division unit
    localparam int NUM_W     = DEV_W + FRAC_BITS;
    localparam int DEN_W     = NN_W;
    localparam int QUO_W     = VAR_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_MEAN,
        ST_DIV_VAR,
        ST_OUT
    } t_back_state;

    typedef enum logic [2:0] {
        MUL_NG_LO,
        MUL_NG_HI,
        MUL_GG_LO,
        MUL_GG_HI,
        MUL_NN_LO,
        MUL_NN_HI,
        MUL_FLUSH
    } t_mul_op;

endpackage

### rtl/roilmgv_if.sv
// ----------------------------------------------------------------------------
// roilmgv interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface roilmgv_pix_if import roilmgv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_rgb565;
    logic             frame_last;

    modport source (output valid, output pixel_rgb565, output frame_last, input ready);
    modport sink   (input valid, input pixel_rgb565, input frame_last, output ready);
endinterface

interface roilmgv_res_if import roilmgv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] mean_luma_q8;
    logic [VAR_W-1:0]  green_variance_q8;
    logic [CNT_W-1:0]  pixels_counted;
    logic              region_empty;

    modport source (output valid, output mean_luma_q8, output green_variance_q8,
                    output pixels_counted, output region_empty, input ready);
    modport sink   (input valid, input mean_luma_q8, input green_variance_q8,
                    input pixels_counted, input region_empty, output ready);
endinterface

interface roilmgv_cfg_if import roilmgv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/roilmgv_front.sv
// ----------------------------------------------------------------------------
// roilmgv_front
// Configuration registers, raster counters, region test, luma pipeline and
// per-frame accumulators. Pushes one stats record per frame.
// ----------------------------------------------------------------------------
module roilmgv_front import roilmgv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    roilmgv_pix_if.sink  i_pix,
    roilmgv_cfg_if.sink  i_cfg,
    output logic         o_push,
    output t_frame_stats o_stats,
    input  logic         i_q_ready
);

    logic [CFG_W-1:0] r_cfg_fw;
    logic [CFG_W-1:0] r_cfg_fh;
    logic [CFG_W-1:0] r_cfg_left;
    logic [CFG_W-1:0] r_cfg_top;
    logic [CFG_W-1:0] r_cfg_rw;
    logic [CFG_W-1:0] r_cfg_rh;

    logic [COL_W-1:0] r_column;
    logic [ROW_W-1:0] r_row;

    logic              r_s1_vld;
    logic              r_s1_in;
    logic              r_s1_last;
    logic [WSUM_W-1:0] r_s1_wsum;
    logic [GREEN_W-1:0] r_s1_green;

    logic               r_s2_vld;
    logic               r_s2_in;
    logic               r_s2_last;
    logic [LUMA_W-1:0]  r_s2_luma;
    logic [GREEN_W-1:0] r_s2_green;
    logic [GSQR_W-1:0]  r_s2_gsq;

    logic [CNT_W-1:0]  r_cnt;
    logic [LSUM_W-1:0] r_lsum;
    logic [GSUM_W-1:0] r_gsum;
    logic [GSQ_W-1:0]  r_gsq;
    logic [CNT_W-1:0]  n_cnt;
    logic [LSUM_W-1:0] n_lsum;
    logic [GSUM_W-1:0] n_gsum;
    logic [GSQ_W-1:0]  n_gsq;

    logic [CFG_W-1:0]   fw;
    logic [CFG_W-1:0]   fh;
    logic signed [REG_S_W-1:0] col_s;
    logic signed [REG_S_W-1:0] row_s;
    logic signed [REG_S_W-1:0] left_s;
    logic signed [REG_S_W-1:0] right_s;
    logic signed [REG_S_W-1:0] top_s;
    logic signed [REG_S_W-1:0] bottom_s;
    logic               in_x;
    logic               in_y;
    logic [RED_W-1:0]   pix_r;
    logic [GREEN_W-1:0] pix_g;
    logic [BLUE_W-1:0]  pix_b;
    logic [WSUM_W-1:0]  wsum;
    logic [LUMA_PROD_W-1:0] luma_prod;
    logic               fire;
    logic               advance;
    logic               accept;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fw   <= FRAME_WIDTH_RST;
            r_cfg_fh   <= FRAME_HEIGHT_RST;
            r_cfg_left <= '0;
            r_cfg_top  <= '0;
            r_cfg_rw   <= '0;
            r_cfg_rh   <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FRAME_WIDTH:   r_cfg_fw   <= i_cfg.data;
                CFG_FRAME_HEIGHT:  r_cfg_fh   <= i_cfg.data;
                CFG_REGION_LEFT:   r_cfg_left <= i_cfg.data;
                CFG_REGION_TOP:    r_cfg_top  <= i_cfg.data;
                CFG_REGION_WIDTH:  r_cfg_rw   <= i_cfg.data;
                CFG_REGION_HEIGHT: r_cfg_rh   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Clamp frame size to 1..MAX_DIM
    always_comb begin
        if (r_cfg_fw == '0) begin
            fw = CFG_W'(1);
        end else if (r_cfg_fw > CFG_W'(MAX_DIM)) begin
            fw = CFG_W'(MAX_DIM);
        end else begin
            fw = r_cfg_fw;
        end
        if (r_cfg_fh == '0) begin
            fh = CFG_W'(1);
        end else if (r_cfg_fh > CFG_W'(MAX_DIM)) begin
            fh = CFG_W'(MAX_DIM);
        end else begin
            fh = r_cfg_fh;
        end
    end

    // Region test in signed arithmetic, clipped by the frame edges
    always_comb begin
        col_s    = signed'(REG_S_W'(r_column));
        row_s    = signed'(REG_S_W'(r_row));
        left_s   = signed'({{(REG_S_W-CFG_W){r_cfg_left[CFG_W-1]}}, r_cfg_left});
        top_s    = signed'({{(REG_S_W-CFG_W){r_cfg_top[CFG_W-1]}}, r_cfg_top});
        right_s  = left_s + signed'(REG_S_W'(r_cfg_rw));
        bottom_s = top_s + signed'(REG_S_W'(r_cfg_rh));
        in_x = (col_s >= left_s) && (col_s < right_s) && (CFG_W'(r_column) < fw);
        in_y = (row_s >= top_s) && (row_s < bottom_s) && (CFG_W'(r_row) < fh);
    end

    assign pix_r = i_pix.pixel_rgb565[PIX_W-1 -: RED_W];
    assign pix_g = i_pix.pixel_rgb565[BLUE_W +: GREEN_W];
    assign pix_b = i_pix.pixel_rgb565[BLUE_W-1:0];
    assign wsum  = WSUM_W'(pix_r) * WSUM_W'(LUMA_R_WT)
                 + WSUM_W'(pix_g) * WSUM_W'(LUMA_G_WT)
                 + WSUM_W'(pix_b) * WSUM_W'(LUMA_B_WT);

    assign luma_prod = LUMA_PROD_W'(r_s1_wsum) * LUMA_PROD_W'(LUMA_RECIP);

    // Whole pipeline holds while a frame end waits for queue space
    assign fire    = r_s2_vld && (!r_s2_last || i_q_ready);
    assign advance = !r_s2_vld || fire;
    assign accept  = i_pix.valid && advance;
    assign i_pix.ready = advance;

    // Raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
        end else if (accept) begin
            if (i_pix.frame_last) begin
                r_column <= '0;
                r_row    <= '0;
            end else if (CFG_W'(r_column) + CFG_W'(1) >= fw) begin
                r_column <= '0;
                if (r_row < ROW_W'(MAX_DIM)) begin
                    r_row <= r_row + ROW_W'(1);
                end
            end else begin
                r_column <= r_column + COL_W'(1);
            end
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (advance) begin
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_in    <= in_x && in_y;
            r_s1_last  <= i_pix.frame_last;
            r_s1_wsum  <= wsum;
            r_s1_green <= pix_g;
            r_s2_in    <= r_s1_in;
            r_s2_last  <= r_s1_last;
            r_s2_luma  <= luma_prod[LUMA_SHIFT +: LUMA_W];
            r_s2_green <= r_s1_green;
            r_s2_gsq   <= GSQR_W'(r_s1_green) * GSQR_W'(r_s1_green);
        end
    end

    // Accumulators
    always_comb begin
        n_cnt  = r_cnt;
        n_lsum = r_lsum;
        n_gsum = r_gsum;
        n_gsq  = r_gsq;
        if (r_s2_in) begin
            n_cnt  = r_cnt + CNT_W'(1);
            n_lsum = r_lsum + LSUM_W'(r_s2_luma);
            n_gsum = r_gsum + GSUM_W'(r_s2_green);
            n_gsq  = r_gsq + GSQ_W'(r_s2_gsq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_lsum <= '0;
            r_gsum <= '0;
            r_gsq  <= '0;
        end else if (fire) begin
            if (r_s2_last) begin
                r_cnt  <= '0;
                r_lsum <= '0;
                r_gsum <= '0;
                r_gsq  <= '0;
            end else begin
                r_cnt  <= n_cnt;
                r_lsum <= n_lsum;
                r_gsum <= n_gsum;
                r_gsq  <= n_gsq;
            end
        end
    end

    assign o_push               = fire && r_s2_last;
    assign o_stats.count        = n_cnt;
    assign o_stats.luma_sum     = n_lsum;
    assign o_stats.green_sum    = n_gsum;
    assign o_stats.green_sq_sum = n_gsq;

endmodule

### rtl/roilmgv_queue.sv
// ----------------------------------------------------------------------------
// roilmgv_queue
// Two-entry queue of frame stats records between front and back.
// ----------------------------------------------------------------------------
module roilmgv_queue import roilmgv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_frame_stats i_stats,
    output logic         o_ready,
    output logic         o_valid,
    output t_frame_stats o_stats,
    input  logic         i_pop
);

    t_frame_stats         r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_stats = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_stats;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

### rtl/roilmgv_div.sv
// ----------------------------------------------------------------------------
// roilmgv_div
// Restoring long division, one quotient bit per cycle. Keeps the low
// quotient bits only.
// ----------------------------------------------------------------------------
module roilmgv_div import roilmgv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/roilmgv_back.sv
// ----------------------------------------------------------------------------
// roilmgv_back
// Per-frame result sequencer: partial-product multiplies for n*sumsq,
// sum^2 and n^2, two long divisions, and the output register.
// ----------------------------------------------------------------------------
module roilmgv_back import roilmgv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_frame_stats  i_q_stats,
    output logic          o_q_pop,
    roilmgv_res_if.source o_res
);

    t_back_state r_state;
    t_back_state n_state;
    t_mul_op     r_op;
    t_mul_op     n_op;
    t_mul_op     r_prod_op;
    logic        r_prod_vld;

    t_frame_stats      r_stats;
    logic [PROD_W-1:0] r_prod;
    logic [NG_W-1:0]   r_acc_ng;
    logic [GG_W-1:0]   r_acc_gg;
    logic [NN_W-1:0]   r_acc_nn;
    logic [DEV_W-1:0]  r_dev;
    logic [MEAN_W-1:0] r_mean;
    logic [VAR_W-1:0]  r_var;
    logic              r_empty;

    logic              r_out_valid;
    logic [MEAN_W-1:0] r_out_mean;
    logic [VAR_W-1:0]  r_out_var;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_empty;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic               load_out;

    roilmgv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        o_q_pop   = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op    = MUL_NG_LO;
                    n_state = (i_q_stats.count == '0) ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL: begin
                case (r_op)
                    MUL_NG_LO: begin
                        mul_a = MUL_A_W'(r_stats.count);
                        mul_b = r_stats.green_sq_sum[MUL_B_W-1:0];
                        n_op  = MUL_NG_HI;
                    end
                    MUL_NG_HI: begin
                        mul_a = MUL_A_W'(r_stats.count);
                        mul_b = r_stats.green_sq_sum[GSQ_W-1:MUL_B_W];
                        n_op  = MUL_GG_LO;
                    end
                    MUL_GG_LO: begin
                        mul_a = r_stats.green_sum;
                        mul_b = r_stats.green_sum[MUL_B_W-1:0];
                        n_op  = MUL_GG_HI;
                    end
                    MUL_GG_HI: begin
                        mul_a = r_stats.green_sum;
                        mul_b = MUL_B_W'(r_stats.green_sum[GSUM_W-1:MUL_B_W]);
                        n_op  = MUL_NN_LO;
                    end
                    MUL_NN_LO: begin
                        mul_a = MUL_A_W'(r_stats.count);
                        mul_b = r_stats.count[MUL_B_W-1:0];
                        n_op  = MUL_NN_HI;
                    end
                    MUL_NN_HI: begin
                        mul_a = MUL_A_W'(r_stats.count);
                        mul_b = MUL_B_W'(r_stats.count[CNT_W-1:MUL_B_W]);
                        n_op  = MUL_FLUSH;
                    end
                    MUL_FLUSH: begin
                        div_start = 1'b1;
                        div_num   = NUM_W'({r_stats.luma_sum, {FRAC_BITS{1'b0}}});
                        div_den   = DEN_W'(r_stats.count);
                        n_state   = ST_DIV_MEAN;
                    end
                    default: n_op = MUL_FLUSH;
                endcase
            end
            ST_DIV_MEAN: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num   = NUM_W'({r_dev, {FRAC_BITS{1'b0}}});
                    div_den   = r_acc_nn;
                    n_state   = ST_DIV_VAR;
                end
            end
            ST_DIV_VAR: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op       <= MUL_NG_LO;
            r_prod_vld <= 1'b0;
        end else begin
            r_op       <= n_op;
            r_prod_vld <= (r_state == ST_MUL) && (r_op != MUL_FLUSH);
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_stats <= i_q_stats;
            r_mean  <= '0;
            r_var   <= '0;
            r_empty <= (i_q_stats.count == '0);
        end
        r_prod    <= PROD_W'(mul_a) * PROD_W'(mul_b);
        r_prod_op <= r_op;
        if (r_prod_vld) begin
            case (r_prod_op)
                MUL_NG_LO: r_acc_ng <= NG_W'(r_prod);
                MUL_NG_HI: r_acc_ng <= r_acc_ng + (NG_W'(r_prod) << MUL_B_W);
                MUL_GG_LO: r_acc_gg <= GG_W'(r_prod);
                MUL_GG_HI: r_acc_gg <= r_acc_gg + (GG_W'(r_prod) << MUL_B_W);
                MUL_NN_LO: r_acc_nn <= NN_W'(r_prod);
                MUL_NN_HI: r_acc_nn <= r_acc_nn + (NN_W'(r_prod) << MUL_B_W);
                default: ;
            endcase
        end
        if ((r_state == ST_MUL) && (r_op == MUL_FLUSH)) begin
            r_dev <= DEV_W'(r_acc_ng - NG_W'(r_acc_gg));
        end
        if ((r_state == ST_DIV_MEAN) && div_done) begin
            r_mean <= div_quo[MEAN_W-1:0];
        end
        if ((r_state == ST_DIV_VAR) && div_done) begin
            r_var <= div_quo;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_mean  <= r_mean;
            r_out_var   <= r_var;
            r_out_count <= r_stats.count;
            r_out_empty <= r_empty;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.mean_luma_q8      = r_out_mean;
    assign o_res.green_variance_q8 = r_out_var;
    assign o_res.pixels_counted    = r_out_count;
    assign o_res.region_empty      = r_out_empty;

endmodule

### rtl/roi_luma_mean_green_variance.sv
// ----------------------------------------------------------------------------
// roi_luma_mean_green_variance
// Per-frame luma mean and green variance over a clipped region of interest.
// ----------------------------------------------------------------------------
// Pixels stream in raster order at one per cycle unless stalled; the front
// keeps raster counters, tests each pixel against the region clipped to the
// frame, and accumulates count, luma sum, green sum and green sum of squares
// through a three-stage pipeline. The pixel flagged frame_last closes the
// frame: its sums go into a two-entry queue and the counters restart. The
// back turns each queued frame into one result with six partial-product
// multiplies and the shared one-bit-per-cycle divider (62 steps for the
// mean, 62 for the variance); an empty region skips both. Pixel input stalls
// only when a frame ends while two finished frames still wait in the
// queue. Configuration writes are accepted every cycle and act from the
// next pixel on.
// ----------------------------------------------------------------------------
module roi_luma_mean_green_variance import roilmgv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    roilmgv_pix_if.sink   i_pix,
    roilmgv_cfg_if.sink   i_cfg,
    roilmgv_res_if.source o_res
);

    logic         push;
    t_frame_stats push_stats;
    logic         q_ready;
    logic         q_valid;
    t_frame_stats q_stats;
    logic         q_pop;

    roilmgv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_cfg     (i_cfg),
        .o_push    (push),
        .o_stats   (push_stats),
        .i_q_ready (q_ready)
    );

    roilmgv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stats (push_stats),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_stats (q_stats),
        .i_pop   (q_pop)
    );

    roilmgv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_stats (q_stats),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule
